[src/kws_pkg.sv]
// Shared types and constants for the windowed KMP byte matcher.
`timescale 1ns / 1ps

package kws_pkg;

  localparam int MAX_PATTERN_DEFAULT = 64;

  localparam int POS_W = 32;
  localparam logic [POS_W-1:0] COUNT_MAX = '1;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_NEW    = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_STOP  = 2'd1,
    CFG_REPORT_LAST  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } state_t;

endpackage

[src/kws_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module kws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/kmp_windowed_search.sv]
// Top level of the windowed KMP byte matcher: sequencer, scan state and stores.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   item     | item_valid / item_stall| action, data_byte
//   result   | result_valid / stall   | match_here, match_position, best_valid,
//            |                        | best_position, match_count, pattern_overflow
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every request passes through an accept state, which issues the store reads, and
// a check state. A text byte or pattern byte stays in the check state while it
// falls back prefix by prefix, as the prefix store has a single read port.
// Reset clears all control and scan state; the stores need no clearing pass.
// A finished request waits in the check cycle while the result register is
// full and stalled; the item side is stalled until the request finishes.
`timescale 1ns / 1ps

module kmp_windowed_search
  import kws_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // item channel
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [1:0]       action,
  input  logic [7:0]       data_byte,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output logic             match_here,
  output logic [POS_W-1:0] match_position,
  output logic             best_valid,
  output logic [POS_W-1:0] best_position,
  output logic [POS_W-1:0] match_count,
  output logic             pattern_overflow,
  // configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int IW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] PLEN_FULL = LW'(MAX_PATTERN);

  // Configuration registers
  logic [POS_W-1:0] window_start;
  logic [POS_W-1:0] window_stop;
  logic             report_last;

  // Pattern and scan state
  state_t           state, state_next;
  logic [LW-1:0]    pattern_length, pattern_length_next;
  logic [IW-1:0]    build_length, build_length_next;
  logic [IW-1:0]    matched_length, matched_length_next;
  logic [POS_W-1:0] text_position, text_position_next;
  logic [POS_W-1:0] found_position, found_position_next;
  logic             found_flag, found_flag_next;
  logic [POS_W-1:0] hit_count, hit_count_next;
  logic             overflow_flag, overflow_flag_next;

  // Request being worked on
  action_t          act, act_next;
  logic [7:0]       byte_q, byte_q_next;
  logic [IW-1:0]    probe, probe_next;

  // Result register
  logic             result_valid_next;
  logic             match_here_next;
  logic [POS_W-1:0] match_position_next;
  logic             best_valid_next;
  logic [POS_W-1:0] best_position_next;
  logic [POS_W-1:0] match_count_next;
  logic             pattern_overflow_next;

  // Store ports
  logic [IW-1:0]    rd_addr;
  logic [7:0]       pat_rdata;
  logic [IW-1:0]    pre_rdata;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [7:0]       wr_pat;
  logic [IW-1:0]    wr_pre;

  // Check-cycle helpers
  logic             out_free;
  logic             loop_op;
  logic             char_eq;
  logic [LW-1:0]    step_len;
  logic [POS_W-1:0] start_at;
  logic             in_window;
  logic             full_match;
  logic             item_take;

  kws_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pat),
    .rd_addr (rd_addr),
    .rd_data (pat_rdata)
  );

  kws_ram #(.WIDTH(IW), .DEPTH(MAX_PATTERN)) u_prefix_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pre),
    .rd_addr (rd_addr - IW'(1)),
    .rd_data (pre_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Combinational helpers for the check cycle
  assign char_eq    = (byte_q == pat_rdata);
  assign loop_op    = ((act == ACT_TEXT) && (pattern_length != '0)) ||
                      ((act == ACT_APPEND) && (pattern_length != '0) &&
                       (pattern_length != PLEN_FULL));
  assign step_len   = LW'(probe) + LW'(char_eq);
  assign full_match = (step_len == pattern_length);
  assign start_at   = text_position + POS_W'(1) - POS_W'(pattern_length);
  assign in_window  = (start_at >= window_start) && (start_at < window_stop);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_stop  <= COUNT_MAX;
      report_last  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_WINDOW_START: window_start <= cfg_data;
        CFG_WINDOW_STOP:  window_stop  <= cfg_data;
        CFG_REPORT_LAST:  report_last  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pattern_length <= '0;
      build_length   <= '0;
      matched_length <= '0;
      text_position  <= '0;
      found_position <= '0;
      found_flag     <= 1'b0;
      hit_count      <= '0;
      overflow_flag  <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      pattern_length <= pattern_length_next;
      build_length   <= build_length_next;
      matched_length <= matched_length_next;
      text_position  <= text_position_next;
      found_position <= found_position_next;
      found_flag     <= found_flag_next;
      hit_count      <= hit_count_next;
      overflow_flag  <= overflow_flag_next;
      result_valid   <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act              <= act_next;
    byte_q           <= byte_q_next;
    probe            <= probe_next;
    match_here       <= match_here_next;
    match_position   <= match_position_next;
    best_valid       <= best_valid_next;
    best_position    <= best_position_next;
    match_count      <= match_count_next;
    pattern_overflow <= pattern_overflow_next;
  end

  // Next state, store access and result
  always_comb begin
    state_next            = state;
    pattern_length_next   = pattern_length;
    build_length_next     = build_length;
    matched_length_next   = matched_length;
    text_position_next    = text_position;
    found_position_next   = found_position;
    found_flag_next       = found_flag;
    hit_count_next        = hit_count;
    overflow_flag_next    = overflow_flag;
    act_next              = act;
    byte_q_next           = byte_q;
    probe_next            = probe;
    result_valid_next     = result_valid && result_stall;
    match_here_next       = match_here;
    match_position_next   = match_position;
    best_valid_next       = best_valid;
    best_position_next    = best_position;
    match_count_next      = match_count;
    pattern_overflow_next = pattern_overflow;
    rd_addr               = probe;
    wr_en                 = 1'b0;
    wr_addr               = pattern_length[IW-1:0];
    wr_pat                = byte_q;
    wr_pre                = step_len[IW-1:0];

    case (state)
      ST_IDLE: begin
        // Latch the request and issue the first store read
        case (action_t'(action))
          ACT_TEXT:   probe_next = matched_length;
          ACT_APPEND: probe_next = build_length;
          default:    probe_next = '0;
        endcase
        rd_addr = probe_next;
        if (item_take) begin
          act_next    = action_t'(action);
          byte_q_next = data_byte;
          state_next  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (loop_op && (probe != '0) && !char_eq) begin
          // Fall back one prefix step and read again
          probe_next = pre_rdata;
          rd_addr    = pre_rdata;
        end else if (out_free) begin
          state_next        = ST_IDLE;
          result_valid_next = 1'b1;
          match_here_next   = 1'b0;
          case (act)
            ACT_NEW: begin
              // Restart the pattern with this byte
              wr_en               = 1'b1;
              wr_addr             = '0;
              wr_pre              = '0;
              pattern_length_next = LW'(1);
              build_length_next   = '0;
              overflow_flag_next  = 1'b0;
              matched_length_next = '0;
              text_position_next  = '0;
              found_position_next = '0;
              found_flag_next     = 1'b0;
              hit_count_next      = '0;
            end
            ACT_APPEND: begin
              matched_length_next = '0;
              text_position_next  = '0;
              found_position_next = '0;
              found_flag_next     = 1'b0;
              hit_count_next      = '0;
              if (pattern_length == PLEN_FULL) begin
                // Drop the byte and flag it
                overflow_flag_next = 1'b1;
              end else if (pattern_length == '0) begin
                wr_en               = 1'b1;
                wr_addr             = '0;
                wr_pre              = '0;
                build_length_next   = '0;
                pattern_length_next = LW'(1);
              end else begin
                wr_en               = 1'b1;
                build_length_next   = step_len[IW-1:0];
                pattern_length_next = pattern_length + LW'(1);
              end
            end
            ACT_TEXT: begin
              text_position_next = text_position + POS_W'(1);
              if (pattern_length != '0) begin
                if (full_match) begin
                  // Last prefix entry equals the build length
                  matched_length_next = build_length;
                  if (in_window) begin
                    match_here_next = 1'b1;
                    if (hit_count != COUNT_MAX) begin
                      hit_count_next = hit_count + POS_W'(1);
                    end
                    if (!found_flag || report_last) begin
                      found_position_next = start_at;
                    end
                    found_flag_next = 1'b1;
                  end
                end else begin
                  matched_length_next = step_len[IW-1:0];
                end
              end
            end
            default: begin
              // End of text: report, then clear the scan state
              matched_length_next = '0;
              text_position_next  = '0;
              found_position_next = '0;
              found_flag_next     = 1'b0;
              hit_count_next      = '0;
            end
          endcase
          match_position_next = match_here_next ? start_at : '0;
          if (act == ACT_END) begin
            best_valid_next    = found_flag;
            best_position_next = found_flag ? found_position : '0;
            match_count_next   = hit_count;
          end else begin
            best_valid_next    = found_flag_next;
            best_position_next = found_flag_next ? found_position_next : '0;
            match_count_next   = hit_count_next;
          end
          pattern_overflow_next = overflow_flag_next;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Matched length always stays below a nonempty pattern length
  assert property (@(posedge clk) disable iff (rst)
    (pattern_length != '0) |-> (LW'(matched_length) < pattern_length))
    else $error("matched length reached pattern length");

  // Build length stays below pattern length
  assert property (@(posedge clk) disable iff (rst)
    (pattern_length != '0) |-> (LW'(build_length) < pattern_length))
    else $error("build length out of range");

  // Pattern length never passes the store size
  assert property (@(posedge clk) disable iff (rst)
    pattern_length <= PLEN_FULL)
    else $error("pattern length beyond store size");

  // A new result only follows a check cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_CHECK))
    else $error("result without a finished request");

endmodule
